[hdl/afc_pkg.sv]
// ----------------------------------------------------------------------------
// afc_pkg
// Shared widths, types and register codes of the box frustum cull block.
// ----------------------------------------------------------------------------
`default_nettype none

package afc_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int COEF_WIDTH  = 16;
    localparam int SLOT_WIDTH  = 16;
    localparam int ROW_WIDTH   = 64;
    localparam int NUM_ROWS    = 4;
    localparam int NUM_COLS    = 4;
    localparam int NUM_AXES    = 3;
    localparam int NUM_PLANES  = 5;
    localparam int CFG_IDX_W   = 8;

    localparam int PROD_W = COEF_WIDTH + COORD_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int D_W    = PROD_W + 1;
    localparam int PB_W   = SUM_W + 1;
    localparam int TOT_W  = PB_W + 2;

    localparam logic [ROW_WIDTH-1:0] ONE_Q = ROW_WIDTH'(4096);

    localparam logic [CFG_IDX_W-1:0] REG_ROW0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROW1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ROW2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ROW3 = CFG_IDX_W'(3);

    localparam int ROW_X = 0;
    localparam int ROW_Y = 1;
    localparam int ROW_Z = 2;
    localparam int ROW_W = 3;

    localparam int PL_LEFT   = 0;
    localparam int PL_RIGHT  = 1;
    localparam int PL_BOTTOM = 2;
    localparam int PL_TOP    = 3;
    localparam int PL_BEHIND = 4;

    typedef logic signed [COEF_WIDTH-1:0]  coef_t;
    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [SUM_W-1:0]       rsum_t;
    typedef logic        [D_W-1:0]         mag_t;
    typedef logic        [ROW_WIDTH-1:0]   row_t;

    typedef coef_t [NUM_COLS-1:0] mrow_t;
    typedef mrow_t [NUM_ROWS-1:0] matrix_t;

    typedef struct packed {
        logic ld0;
        logic ld1;
        logic ld2;
        logic ld3;
    } afc_pipe_en_t;

    typedef struct packed {
        logic culled;
        logic all_left;
        logic all_right;
        logic all_bottom;
        logic all_top;
        logic all_behind;
    } afc_flags_t;

endpackage

`default_nettype wire

[hdl/aabb_frustum_cull.sv]
// ----------------------------------------------------------------------------
// aabb_frustum_cull
// Clip-space frustum cull of an axis-aligned box against a 4x4 matrix.
// ----------------------------------------------------------------------------
// Takes one box per clock while nothing stalls and returns one result per
// box, in order, held in the result register until taken. The pipeline is an
// input register, a product stage (28 parallel multipliers: the matrix times
// the center, and each coefficient of the first three columns times its half
// extent), a row-sum stage that also forms the per-plane extent magnitudes,
// and the plane test feeding the result register. Each plane is tested on its
// worst corner, which gives the exact answer of testing all eight. A held
// out_stall freezes the results and backs up through stages that are full;
// empty stages keep taking items. Matrix rows reset to identity and may be
// written only while no box is in flight; cfg_ready is always high and writes
// to an index above three are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_frustum_cull
    import afc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output      logic                 in_stall,
    input  wire coord_t               center_x,
    input  wire coord_t               center_y,
    input  wire coord_t               center_z,
    input  wire coord_t               center_w,
    input  wire coord_t               extent_x,
    input  wire coord_t               extent_y,
    input  wire coord_t               extent_z,

    output      logic                 out_valid,
    input  wire logic                 out_stall,
    output      logic                 culled,
    output      logic                 all_left,
    output      logic                 all_right,
    output      logic                 all_bottom,
    output      logic                 all_top,
    output      logic                 all_behind,

    input  wire logic                 cfg_valid,
    output      logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ROW_WIDTH-1:0] cfg_data
);

    logic [3:0] vld_reg;
    logic [3:0] vld_next;
    logic [3:0] free;

    afc_pipe_en_t en;
    matrix_t      matrix;
    afc_flags_t   flags;

    rsum_t [NUM_ROWS-1:0]                 base;
    mag_t  [NUM_PLANES-1:0][NUM_AXES-1:0] mag;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        free[3] = !vld_reg[3] || !out_stall;
        free[2] = !vld_reg[2] || free[3];
        free[1] = !vld_reg[1] || free[2];
        free[0] = !vld_reg[0] || free[1];

        en.ld0 = in_valid   && free[0];
        en.ld1 = vld_reg[0] && free[1];
        en.ld2 = vld_reg[1] && free[2];
        en.ld3 = vld_reg[2] && free[3];

        vld_next[0] = free[0] ? in_valid   : vld_reg[0];
        vld_next[1] = free[1] ? vld_reg[0] : vld_reg[1];
        vld_next[2] = free[2] ? vld_reg[1] : vld_reg[2];
        vld_next[3] = free[3] ? vld_reg[2] : vld_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = !free[0];
    assign out_valid = vld_reg[3];

    afc_matrix_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .matrix    (matrix)
    );

    afc_transform u_xform (
        .clk      (clk),
        .en       (en),
        .matrix   (matrix),
        .center_x (center_x),
        .center_y (center_y),
        .center_z (center_z),
        .center_w (center_w),
        .extent_x (extent_x),
        .extent_y (extent_y),
        .extent_z (extent_z),
        .base     (base),
        .mag      (mag)
    );

    afc_plane_test u_test (
        .clk   (clk),
        .load  (en.ld3),
        .base  (base),
        .mag   (mag),
        .flags (flags)
    );

    assign culled     = flags.culled;
    assign all_left   = flags.all_left;
    assign all_right  = flags.all_right;
    assign all_bottom = flags.all_bottom;
    assign all_top    = flags.all_top;
    assign all_behind = flags.all_behind;

    a_full_backs_up: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg == 4'b1111 && out_stall) |-> in_stall)
        else $error("full stalled pipeline still takes an item");

    a_culled_or: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (culled == (all_left || all_right || all_bottom
                                  || all_top || all_behind)))
        else $error("culled disagrees with plane flags");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (!vld_reg[2] && !vld_reg[3]) |=> !out_valid)
        else $error("result appears without an item behind it");

    a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted item not held in input stage");

endmodule

`default_nettype wire

[hdl/afc_matrix_regs.sv]
// ----------------------------------------------------------------------------
// afc_matrix_regs
// View-projection matrix row registers with write decode and unpacking.
// ----------------------------------------------------------------------------
`default_nettype none

module afc_matrix_regs
    import afc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ROW_WIDTH-1:0] cfg_data,
    output matrix_t                   matrix
);

    row_t [NUM_ROWS-1:0] row_reg;
    row_t [NUM_ROWS-1:0] row_next;

    always_comb
    begin
        row_next = row_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW0: row_next[0] = cfg_data;
                REG_ROW1: row_next[1] = cfg_data;
                REG_ROW2: row_next[2] = cfg_data;
                REG_ROW3: row_next[3] = cfg_data;
                default:  row_next    = row_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                row_reg[r] <= ONE_Q << (SLOT_WIDTH * r);
            end
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                matrix[r][c] = row_reg[r][SLOT_WIDTH*c +: COEF_WIDTH];
            end
        end
    end

endmodule

`default_nettype wire

[hdl/afc_transform.sv]
// ----------------------------------------------------------------------------
// afc_transform
// Input register, matrix products of center and extents, row sums and
// per-plane extent magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module afc_transform
    import afc_pkg::*;
(
    input  wire logic   clk,
    input  wire afc_pipe_en_t en,
    input  wire matrix_t     matrix,
    input  wire coord_t      center_x,
    input  wire coord_t      center_y,
    input  wire coord_t      center_z,
    input  wire coord_t      center_w,
    input  wire coord_t      extent_x,
    input  wire coord_t      extent_y,
    input  wire coord_t      extent_z,
    output rsum_t [NUM_ROWS-1:0]                 base,
    output mag_t  [NUM_PLANES-1:0][NUM_AXES-1:0] mag
);

    coord_t [NUM_COLS-1:0] ctr_reg;
    coord_t [NUM_AXES-1:0] ext_reg;

    prod_t [NUM_ROWS-1:0][NUM_COLS-1:0] pc_reg;
    prod_t [NUM_ROWS-1:0][NUM_COLS-1:0] pc_next;
    prod_t [NUM_ROWS-1:0][NUM_AXES-1:0] pe_reg;
    prod_t [NUM_ROWS-1:0][NUM_AXES-1:0] pe_next;

    rsum_t [NUM_ROWS-1:0]                 base_reg;
    rsum_t [NUM_ROWS-1:0]                 base_next;
    mag_t  [NUM_PLANES-1:0][NUM_AXES-1:0] mag_reg;
    mag_t  [NUM_PLANES-1:0][NUM_AXES-1:0] mag_next;

    logic signed [D_W-1:0] d [NUM_PLANES][NUM_AXES];

    always_ff @(posedge clk)
    begin
        if (en.ld0)
        begin
            ctr_reg <= {center_w, center_z, center_y, center_x};
            ext_reg <= {extent_z, extent_y, extent_x};
        end
    end

    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                pc_next[r][c] = $signed(matrix[r][c]) * $signed(ctr_reg[c]);
            end
            for (int j = 0; j < NUM_AXES; j++)
            begin
                pe_next[r][j] = $signed(matrix[r][j]) * $signed(ext_reg[j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.ld1)
        begin
            pc_reg <= pc_next;
            pe_reg <= pe_next;
        end
    end

    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            base_next[r] = SUM_W'($signed(pc_reg[r][0])) + SUM_W'($signed(pc_reg[r][1]))
                         + SUM_W'($signed(pc_reg[r][2])) + SUM_W'($signed(pc_reg[r][3]));
        end
        for (int j = 0; j < NUM_AXES; j++)
        begin
            d[PL_LEFT][j]   = D_W'($signed(pe_reg[ROW_X][j])) + D_W'($signed(pe_reg[ROW_W][j]));
            d[PL_RIGHT][j]  = D_W'($signed(pe_reg[ROW_X][j])) - D_W'($signed(pe_reg[ROW_W][j]));
            d[PL_BOTTOM][j] = D_W'($signed(pe_reg[ROW_Y][j])) + D_W'($signed(pe_reg[ROW_W][j]));
            d[PL_TOP][j]    = D_W'($signed(pe_reg[ROW_Y][j])) - D_W'($signed(pe_reg[ROW_W][j]));
            d[PL_BEHIND][j] = D_W'($signed(pe_reg[ROW_Z][j]));
        end
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            for (int j = 0; j < NUM_AXES; j++)
            begin
                mag_next[p][j] = d[p][j][D_W-1] ? mag_t'(-d[p][j]) : mag_t'(d[p][j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.ld2)
        begin
            base_reg <= base_next;
            mag_reg  <= mag_next;
        end
    end

    assign base = base_reg;
    assign mag  = mag_reg;

endmodule

`default_nettype wire

[hdl/afc_plane_test.sv]
// ----------------------------------------------------------------------------
// afc_plane_test
// Worst-corner test against each clip plane and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module afc_plane_test
    import afc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   load,
    input  wire rsum_t [NUM_ROWS-1:0]                 base,
    input  wire mag_t  [NUM_PLANES-1:0][NUM_AXES-1:0] mag,
    output afc_flags_t  flags
);

    logic signed [PB_W-1:0]  pbase [NUM_PLANES];
    logic signed [TOT_W-1:0] msum  [NUM_PLANES];
    logic signed [TOT_W-1:0] worst [NUM_PLANES];

    afc_flags_t flags_reg;
    afc_flags_t flags_next;

    always_comb
    begin
        pbase[PL_LEFT]   = PB_W'($signed(base[ROW_X])) + PB_W'($signed(base[ROW_W]));
        pbase[PL_RIGHT]  = PB_W'($signed(base[ROW_X])) - PB_W'($signed(base[ROW_W]));
        pbase[PL_BOTTOM] = PB_W'($signed(base[ROW_Y])) + PB_W'($signed(base[ROW_W]));
        pbase[PL_TOP]    = PB_W'($signed(base[ROW_Y])) - PB_W'($signed(base[ROW_W]));
        pbase[PL_BEHIND] = PB_W'($signed(base[ROW_Z]));

        for (int p = 0; p < NUM_PLANES; p++)
        begin
            msum[p] = $signed(TOT_W'(mag[p][0])) + $signed(TOT_W'(mag[p][1]))
                    + $signed(TOT_W'(mag[p][2]));
        end

        // left, bottom, behind: the largest corner value must stay below zero
        // right, top: the smallest corner value must stay above zero
        worst[PL_LEFT]   = TOT_W'(pbase[PL_LEFT])   + msum[PL_LEFT];
        worst[PL_RIGHT]  = TOT_W'(pbase[PL_RIGHT])  - msum[PL_RIGHT];
        worst[PL_BOTTOM] = TOT_W'(pbase[PL_BOTTOM]) + msum[PL_BOTTOM];
        worst[PL_TOP]    = TOT_W'(pbase[PL_TOP])    - msum[PL_TOP];
        worst[PL_BEHIND] = TOT_W'(pbase[PL_BEHIND]) + msum[PL_BEHIND];

        flags_next.all_left   = worst[PL_LEFT][TOT_W-1];
        flags_next.all_right  = !worst[PL_RIGHT][TOT_W-1] && (worst[PL_RIGHT] != '0);
        flags_next.all_bottom = worst[PL_BOTTOM][TOT_W-1];
        flags_next.all_top    = !worst[PL_TOP][TOT_W-1] && (worst[PL_TOP] != '0);
        flags_next.all_behind = worst[PL_BEHIND][TOT_W-1];
        flags_next.culled     = flags_next.all_left | flags_next.all_right
                              | flags_next.all_bottom | flags_next.all_top
                              | flags_next.all_behind;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

`default_nettype wire

[tb/aabb_frustum_cull_check.sv]
// ----------------------------------------------------------------------------
// aabb_frustum_cull_check
// Watches the box, result and register channels of the frustum cull block.
// ----------------------------------------------------------------------------
// Keeps its own copy of the four matrix rows, updated on every accepted
// write to rows 0 to 3. For each accepted box it transforms all eight
// corners exactly in 64-bit integers and queues the plane flags. Each accepted
// result is compared flag by flag with the oldest queued entry. The failure
// count and the number of outstanding boxes go back to the testbench top.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_check
    import afc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    input  logic                 in_stall,
    input  coord_t               center_x,
    input  coord_t               center_y,
    input  coord_t               center_z,
    input  coord_t               center_w,
    input  coord_t               extent_x,
    input  coord_t               extent_y,
    input  coord_t               extent_z,

    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 culled,
    input  logic                 all_left,
    input  logic                 all_right,
    input  logic                 all_bottom,
    input  logic                 all_top,
    input  logic                 all_behind,

    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  row_t                 cfg_data,

    output int                   fail_count,
    output int                   pending,
    output int                   results_seen,
    output int                   culled_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CORNERS = 8;
    localparam int NUM_FLAGS   = 6;

    row_t       clip_rows [NUM_ROWS];
    afc_flags_t expected_flags [$];
    string      flag_names [NUM_FLAGS] =
        '{"all_behind", "all_top", "all_bottom", "all_right", "all_left", "culled"};

    function automatic afc_flags_t cull_flags(input coord_t cx, cy, cz, cw, ex, ey, ez);
        longint     p [NUM_COLS];
        longint     clip [NUM_ROWS];
        logic       lft, rgt, bot, top, bhd;
        afc_flags_t f;
        lft = 1'b1;
        rgt = 1'b1;
        bot = 1'b1;
        top = 1'b1;
        bhd = 1'b1;
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            p[0] = k[2] ? longint'(cx) - longint'(ex) : longint'(cx) + longint'(ex);
            p[1] = k[1] ? longint'(cy) - longint'(ey) : longint'(cy) + longint'(ey);
            p[2] = k[0] ? longint'(cz) - longint'(ez) : longint'(cz) + longint'(ez);
            p[3] = longint'(cw);
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                clip[r] = 0;
                for (int j = 0; j < NUM_COLS; j++)
                    clip[r] += longint'(coef_t'(clip_rows[r][SLOT_WIDTH*j +: COEF_WIDTH]))
                               * p[j];
            end
            if (!(clip[ROW_X] < -clip[ROW_W])) lft = 1'b0;
            if (!(clip[ROW_X] >  clip[ROW_W])) rgt = 1'b0;
            if (!(clip[ROW_Y] < -clip[ROW_W])) bot = 1'b0;
            if (!(clip[ROW_Y] >  clip[ROW_W])) top = 1'b0;
            if (!(clip[ROW_Z] < 0))            bhd = 1'b0;
        end
        f.all_left   = lft;
        f.all_right  = rgt;
        f.all_bottom = bot;
        f.all_top    = top;
        f.all_behind = bhd;
        f.culled     = lft | rgt | bot | top | bhd;
        return f;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        afc_flags_t got;
        afc_flags_t want;
        if (!rst_n)
        begin
            clip_rows[ROW_X] = ONE_Q;
            clip_rows[ROW_Y] = ONE_Q << (SLOT_WIDTH * ROW_Y);
            clip_rows[ROW_Z] = ONE_Q << (SLOT_WIDTH * ROW_Z);
            clip_rows[ROW_W] = ONE_Q << (SLOT_WIDTH * ROW_W);
            expected_flags.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ROW0: clip_rows[ROW_X] = cfg_data;
                    REG_ROW1: clip_rows[ROW_Y] = cfg_data;
                    REG_ROW2: clip_rows[ROW_Z] = cfg_data;
                    REG_ROW3: clip_rows[ROW_W] = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                got = {culled, all_left, all_right, all_bottom, all_top, all_behind};
                results_seen++;
                if (culled)
                    culled_seen++;
                if (expected_flags.size() == 0)
                begin
                    $error("result arrived with no box outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_flags.pop_front();
                    for (int i = 0; i < NUM_FLAGS; i++)
                    begin
                        if (got[i] !== want[i])
                        begin
                            $error("%s: expected %0b, got %0b", flag_names[i], want[i], got[i]);
                            fail_count++;
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_flags.push_back(cull_flags(center_x, center_y, center_z, center_w,
                                                    extent_x, extent_y, extent_z));
            pending <= expected_flags.size();
        end
    end

endmodule

[tb/aabb_frustum_cull_test.sv]
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test
// Stimulus and verdict for the box frustum cull block.
// ----------------------------------------------------------------------------
// Runs directed boxes on the reset matrix (plane boundaries, negative
// extents, zero and negative w, field extremes), then eight phases of random
// boxes, each under a newly loaded matrix and a chosen mix of sender gaps and
// receiver stalls. One phase holds the result side off for a long stretch;
// another drains the pipeline mid-stream. The checker module predicts and
// compares; this module only drives and reports.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_test;
    import afc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        coord_t cx;
        coord_t cy;
        coord_t cz;
        coord_t cw;
        coord_t ex;
        coord_t ey;
        coord_t ez;
    } box_t;

    typedef enum {MX_IDENTITY, MX_PERSPECTIVE, MX_ALL_MAX, MX_ALL_MIN, MX_ZERO,
                  MX_RANDOM, MX_SMALL} matrix_kind_e;
    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_e;

    localparam int     BOX_FIELDS   = 7;
    localparam int     NUM_PHASES   = 8;
    localparam int     PHASE_ITEMS  = 140;
    localparam int     HOLD_PHASE   = 0;
    localparam int     HOLD_AT      = 40;
    localparam int     HOLD_CYCLES  = 64;
    localparam int     PAUSE_PHASE  = 4;
    localparam int     PAUSE_AT     = 70;
    localparam int     DRAIN_CYCLES = 12;
    localparam int     LIMIT_CYCLES = 200000;
    localparam coord_t W_ONE        = 16;
    localparam coef_t  Q_ONE        = 4096;
    localparam coef_t  Q_NEG        = -4096;
    localparam coef_t  C_MAX        = 16'sh7FFF;
    localparam coef_t  C_MIN        = 16'sh8000;
    localparam coord_t EDGE_VALS [6] = '{-32768, -1, 0, 1, 16, 32767};

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    coord_t               center_x, center_y, center_z, center_w;
    coord_t               extent_x, extent_y, extent_z;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 culled, all_left, all_right, all_bottom, all_top, all_behind;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    row_t                 cfg_data;

    int    fail_count;
    int    pending;
    int    results_seen;
    int    culled_seen;
    int    boxes_sent;
    int    cycle_count;
    int    sender_idle_pct;
    int    recv_stall_pct;
    int    hold_left;
    bit    hold_go;
    bit    hold_taken;
    row_t  mat [NUM_ROWS];

    matrix_kind_e phase_matrix [NUM_PHASES] = '{MX_PERSPECTIVE, MX_ALL_MAX, MX_RANDOM,
        MX_ALL_MIN, MX_SMALL, MX_ZERO, MX_RANDOM, MX_IDENTITY};
    idle_e phase_idle [NUM_PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
        IDLE_NONE, IDLE_SENDER, IDLE_BOTH, IDLE_RECEIVER};

    aabb_frustum_cull DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .center_x   (center_x),
        .center_y   (center_y),
        .center_z   (center_z),
        .center_w   (center_w),
        .extent_x   (extent_x),
        .extent_y   (extent_y),
        .extent_z   (extent_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .culled     (culled),
        .all_left   (all_left),
        .all_right  (all_right),
        .all_bottom (all_bottom),
        .all_top    (all_top),
        .all_behind (all_behind),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    aabb_frustum_cull_check checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .center_x     (center_x),
        .center_y     (center_y),
        .center_z     (center_z),
        .center_w     (center_w),
        .extent_x     (extent_x),
        .extent_y     (extent_y),
        .extent_z     (extent_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .culled       (culled),
        .all_left     (all_left),
        .all_right    (all_right),
        .all_bottom   (all_bottom),
        .all_top      (all_top),
        .all_behind   (all_behind),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .culled_seen  (culled_seen)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_go && !hold_taken)
        begin
            hold_left = HOLD_CYCLES;
            hold_taken = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    function automatic row_t pack_row(input coef_t c0, c1, c2, c3);
        return {c3, c2, c1, c0};
    endfunction

    function automatic box_t mk_box(input int cx, cy, cz, cw, ex, ey, ez);
        box_t b;
        b.cx = coord_t'(cx);
        b.cy = coord_t'(cy);
        b.cz = coord_t'(cz);
        b.cw = coord_t'(cw);
        b.ex = coord_t'(ex);
        b.ey = coord_t'(ey);
        b.ez = coord_t'(ez);
        return b;
    endfunction

    function automatic box_t make_box();
        box_t b;
        int   pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            b.cw = ($urandom_range(0, 3) == 0) ? coord_t'($urandom_range(1, 64)) : W_ONE;
            b.cx = coord_t'(int'($urandom_range(0, 600)) - 300);
            b.cy = coord_t'(int'($urandom_range(0, 600)) - 300);
            b.cz = coord_t'(int'($urandom_range(0, 600)) - 300);
            b.ex = coord_t'($urandom_range(0, 60));
            b.ey = coord_t'($urandom_range(0, 60));
            b.ez = coord_t'($urandom_range(0, 60));
            if ($urandom_range(0, 7) == 0)
            begin
                b.ex = -b.ex;
                b.ez = -b.ez;
            end
        end
        else if (pick < 8)
        begin
            for (int i = 0; i < BOX_FIELDS; i++)
                b[COORD_WIDTH*i +: COORD_WIDTH] = COORD_WIDTH'($urandom);
        end
        else
        begin
            for (int i = 0; i < BOX_FIELDS; i++)
                b[COORD_WIDTH*i +: COORD_WIDTH] = EDGE_VALS[$urandom_range(0, 5)];
        end
        return b;
    endfunction

    task automatic put_box(input box_t b);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        center_x <= b.cx;
        center_y <= b.cy;
        center_z <= b.cz;
        center_w <= b.cw;
        extent_x <= b.ex;
        extent_y <= b.ey;
        extent_z <= b.ez;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        boxes_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input row_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic load_matrix();
        cfg_write(CFG_IDX_W'($urandom_range(4, 255)), {$urandom, $urandom});
        cfg_write(REG_ROW0, mat[ROW_X]);
        cfg_write(REG_ROW1, mat[ROW_Y]);
        cfg_write(REG_ROW2, mat[ROW_Z]);
        cfg_write(REG_ROW3, mat[ROW_W]);
        cfg_valid <= 1'b0;
    endtask

    task automatic choose_matrix(input matrix_kind_e kind);
        case (kind)
            MX_IDENTITY:
            begin
                mat[ROW_X] = pack_row(Q_ONE, 0, 0, 0);
                mat[ROW_Y] = pack_row(0, Q_ONE, 0, 0);
                mat[ROW_Z] = pack_row(0, 0, Q_ONE, 0);
                mat[ROW_W] = pack_row(0, 0, 0, Q_ONE);
            end
            MX_PERSPECTIVE:
            begin
                mat[ROW_X] = pack_row(Q_ONE, 0, 0, 0);
                mat[ROW_Y] = pack_row(0, Q_ONE, 0, 0);
                mat[ROW_Z] = pack_row(0, 0, Q_NEG, Q_NEG);
                mat[ROW_W] = pack_row(0, 0, Q_NEG, 0);
            end
            MX_ALL_MAX:
                for (int r = 0; r < NUM_ROWS; r++)
                    mat[r] = pack_row(C_MAX, C_MAX, C_MAX, C_MAX);
            MX_ALL_MIN:
                for (int r = 0; r < NUM_ROWS; r++)
                    mat[r] = pack_row(C_MIN, C_MIN, C_MIN, C_MIN);
            MX_ZERO:
                for (int r = 0; r < NUM_ROWS; r++)
                    mat[r] = '0;
            MX_RANDOM:
                for (int r = 0; r < NUM_ROWS; r++)
                    mat[r] = {$urandom, $urandom};
            MX_SMALL:
                for (int r = 0; r < NUM_ROWS; r++)
                    for (int j = 0; j < NUM_COLS; j++)
                        mat[r][SLOT_WIDTH*j +: SLOT_WIDTH] =
                            coef_t'(int'($urandom_range(0, 16383)) - 8192);
            default: ;
        endcase
    endtask

    task automatic set_idle(input idle_e mode);
        case (mode)
            IDLE_NONE:     begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin sender_idle_pct = 49; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  recv_stall_pct = 49; end
            IDLE_BOTH:     begin sender_idle_pct = 9;  recv_stall_pct = 9;  end
            default: ;
        endcase
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        center_x  <= '0;
        center_y  <= '0;
        center_z  <= '0;
        center_w  <= '0;
        extent_x  <= '0;
        extent_y  <= '0;
        extent_z  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_ROW0;
        cfg_data  <= '0;
        set_idle(IDLE_NONE);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put_box(mk_box(0, 0, 0, 0, 0, 0, 0));
        put_box(mk_box(0, 0, 0, 16, 8, 8, 8));
        put_box(mk_box(-100, 0, 8, 16, 8, 8, 4));
        put_box(mk_box(100, 0, 8, 16, 8, 8, 4));
        put_box(mk_box(0, -100, 8, 16, 8, 8, 4));
        put_box(mk_box(0, 100, 8, 16, 8, 8, 4));
        put_box(mk_box(0, 0, -100, 16, 8, 8, 8));
        put_box(mk_box(-100, 0, 8, 16, -8, -8, -4));
        put_box(mk_box(-20, 0, 8, 16, 8, 8, 4));
        put_box(mk_box(-24, 0, 8, 16, 8, 8, 4));
        put_box(mk_box(0, 0, -8, 16, 0, 0, 8));
        put_box(mk_box(0, 0, 0, -16, 4, 4, 4));
        put_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        put_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
        put_box(mk_box(32767, 32767, 32767, 32767, -32768, -32768, -32768));
        put_box(mk_box(-32768, -32768, -32768, -32768, 32767, 32767, 32767));
        put_box(mk_box(-32768, 32767, -32768, 16, 0, 0, 0));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            choose_matrix(phase_matrix[p]);
            load_matrix();
            set_idle(phase_idle[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == HOLD_PHASE && n == HOLD_AT)
                    hold_go = 1'b1;
                if (p == PAUSE_PHASE && n == PAUSE_AT)
                    drain();
                put_box(make_box());
            end
        end
        drain();

        $display("Sent %0d boxes through %0d matrix settings with mixed gaps and stalls.",
                 boxes_sent, NUM_PHASES + 1);
        $display("Checked %0d results, %0d of them culled.", results_seen, culled_seen);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
hdl/afc_pkg.sv
hdl/afc_matrix_regs.sv
hdl/afc_transform.sv
hdl/afc_plane_test.sv
hdl/aabb_frustum_cull.sv
tb/aabb_frustum_cull_check.sv
tb/aabb_frustum_cull_test.sv
